### rtl/nmk_pkg.sv
package nmk_pkg;

    // Field widths fixed by the interface.
    localparam int FIELD_W   = 64;
    localparam int CFG_W     = 63;
    localparam int CFG_IDX_W = 3;

    // Shared multiplier: 64-bit magnitudes taken as 32-bit halves.
    localparam int MUL_HALF_W = 32;
    localparam int MUL_MAG_W  = 2 * MUL_HALF_W;
    localparam int MUL_PROD_W = 2 * MUL_MAG_W;

    // Microcode program counter.
    localparam int UPC_W = 5;
    localparam logic [UPC_W-1:0] UPC_AXIS_START = 5'd1;
    localparam logic [UPC_W-1:0] UPC_DONE       = 5'd20;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TWO_OVER_STEP       = 3'd0,
        REG_FOUR_OVER_STEP_SQ   = 3'd1,
        REG_HEAVE_MASS          = 3'd2,
        REG_HEAVE_DAMPING       = 3'd3,
        REG_HEAVE_INV_STIFFNESS = 3'd4,
        REG_PITCH_INERTIA       = 3'd5,
        REG_PITCH_DAMPING       = 3'd6,
        REG_PITCH_INV_STIFFNESS = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [FIELD_W-1:0] heave_force;
        logic signed [FIELD_W-1:0] pitch_moment;
        logic                      integrate_enable;
    } t_in;

    typedef struct packed {
        logic signed [FIELD_W-1:0] heave_disp;
        logic signed [FIELD_W-1:0] heave_vel;
        logic signed [FIELD_W-1:0] heave_acc;
        logic signed [FIELD_W-1:0] pitch_angle;
        logic signed [FIELD_W-1:0] pitch_rate;
        logic signed [FIELD_W-1:0] pitch_accel;
        logic                      saturated;
    } t_out;

    typedef enum logic [2:0] {
        OP_NOP  = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DONE = 3'd4
    } t_op;

    typedef enum logic [3:0] {
        SRC_H2   = 4'd0,
        SRC_Q    = 4'd1,
        SRC_MASS = 4'd2,
        SRC_DAMP = 4'd3,
        SRC_RINV = 4'd4,
        SRC_Y    = 4'd5,
        SRC_V    = 4'd6,
        SRC_A    = 4'd7,
        SRC_F    = 4'd8,
        SRC_T0   = 4'd9,
        SRC_T1   = 4'd10,
        SRC_T2   = 4'd11,
        SRC_T3   = 4'd12,
        SRC_T4   = 4'd13
    } t_src;

    typedef enum logic [2:0] {
        DST_T0 = 3'd0,
        DST_T1 = 3'd1,
        DST_T2 = 3'd2,
        DST_T3 = 3'd3,
        DST_T4 = 3'd4
    } t_dst;

    typedef enum logic [1:0] {
        J_NONE      = 2'd0,
        J_DISABLED  = 2'd1,
        J_AXIS_LOOP = 2'd2
    } t_jcond;

    typedef struct packed {
        t_op              op;
        t_src             src_a;
        t_src             src_b;
        t_dst             dst;
        t_jcond           jc;
        logic [UPC_W-1:0] target;
        logic             commit;
    } t_uop;

    function automatic t_uop uop(input t_op op, input t_src a, input t_src b,
                                 input t_dst d);
        t_uop u;
        u.op     = op;
        u.src_a  = a;
        u.src_b  = b;
        u.dst    = d;
        u.jc     = J_NONE;
        u.target = '0;
        u.commit = 1'b0;
        return u;
    endfunction

    // One axis of the Newmark step. The program runs steps 1 to 19 once for
    // heave and once for pitch; the axis register picks the operands.
    function automatic t_uop uc_rom(input logic [UPC_W-1:0] pc);
        t_uop u;
        u = uop(OP_NOP, SRC_H2, SRC_H2, DST_T0);
        case (pc)
            5'd0: begin
                u.jc     = J_DISABLED;
                u.target = UPC_DONE;
            end
            5'd1:  u = uop(OP_ADD, SRC_H2,   SRC_H2,   DST_T4);
            5'd2:  u = uop(OP_MUL, SRC_Q,    SRC_Y,    DST_T0);
            5'd3:  u = uop(OP_MUL, SRC_T4,   SRC_V,    DST_T1);
            5'd4:  u = uop(OP_ADD, SRC_T0,   SRC_T1,   DST_T0);
            5'd5:  u = uop(OP_ADD, SRC_T0,   SRC_A,    DST_T0);
            5'd6:  u = uop(OP_MUL, SRC_H2,   SRC_Y,    DST_T2);
            5'd7:  u = uop(OP_ADD, SRC_T2,   SRC_V,    DST_T2);
            5'd8:  u = uop(OP_MUL, SRC_MASS, SRC_T0,   DST_T0);
            5'd9:  u = uop(OP_ADD, SRC_F,    SRC_T0,   DST_T0);
            5'd10: u = uop(OP_MUL, SRC_DAMP, SRC_T2,   DST_T2);
            5'd11: u = uop(OP_ADD, SRC_T0,   SRC_T2,   DST_T0);
            5'd12: u = uop(OP_MUL, SRC_T0,   SRC_RINV, DST_T3);
            5'd13: u = uop(OP_SUB, SRC_T3,   SRC_Y,    DST_T2);
            5'd14: u = uop(OP_MUL, SRC_Q,    SRC_T2,   DST_T0);
            5'd15: u = uop(OP_SUB, SRC_T0,   SRC_T1,   DST_T0);
            5'd16: u = uop(OP_SUB, SRC_T0,   SRC_A,    DST_T0);
            5'd17: u = uop(OP_MUL, SRC_H2,   SRC_T2,   DST_T4);
            5'd18: u = uop(OP_SUB, SRC_T4,   SRC_V,    DST_T4);
            5'd19: begin
                u.commit = 1'b1;
                u.jc     = J_AXIS_LOOP;
                u.target = UPC_AXIS_START;
            end
            5'd20: u = uop(OP_DONE, SRC_H2, SRC_H2, DST_T0);
            default: u = uop(OP_DONE, SRC_H2, SRC_H2, DST_T0);
        endcase
        return u;
    endfunction

endpackage

### rtl/newmark_two_dof_step.sv
// Channel  Direction  Handshake                  Payload
// in       input      i_in_valid / o_in_stall    i_in_data  (nmk_pkg::t_in)
// out      output     o_out_valid / i_out_stall  o_out_data (nmk_pkg::t_out)
// cfg      input      i_cfg_we                   i_cfg_index, i_cfg_data
//
// An enabled transaction runs 16 products on the one shared multiplier
// (each from four 32x32 partial products, a rounding step and a clamp step),
// 20 sums, two commits and the program entry and exit. A disabled one only
// enters the program and jumps to its exit. Input is taken only in idle.
// Reset is synchronous and active low; it clears the control state, the
// configuration, the oscillator state and the output valid flag.
// A result waiting under stall holds the program at its last step; input is
// taken again once the result is in the output register.
//
// A microcoded sequencer drives the datapath: each control word names an
// operation, two operands, a destination temporary, and an optional jump.
// The same program runs once per axis, with an axis bit choosing the
// coefficients and state of heave or pitch.
module newmark_two_dof_step #(
    parameter int DATA_WIDTH = 64,
    parameter int FRAC_BITS  = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  nmk_pkg::t_in                        i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output nmk_pkg::t_out                       o_out_data,
    input  logic                                i_cfg_we,
    input  logic [nmk_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [nmk_pkg::CFG_W-1:0]           i_cfg_data
);

    localparam int DW = DATA_WIDTH;
    localparam int FW = nmk_pkg::FIELD_W;
    localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_MULW = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic [nmk_pkg::UPC_W-1:0] r_upc, n_upc;
    logic r_axis, n_axis;

    // Configuration registers, clamped to the signed range on write.
    logic signed [DW-1:0] r_h2, r_q4;
    logic signed [DW-1:0] r_hmass, r_hdamp, r_hrinv;
    logic signed [DW-1:0] r_pmass, r_pdamp, r_prinv;

    // Oscillator state for both axes.
    logic signed [DW-1:0] r_hy, r_hv, r_ha, r_py, r_pv, r_pa;

    // Captured transaction and working temporaries.
    logic signed [DW-1:0] r_hf, r_pf;
    logic r_en, r_sat;
    logic signed [DW-1:0] r_t0, r_t1, r_t2, r_t3, r_t4;

    logic          r_out_valid;
    nmk_pkg::t_out r_out;

    nmk_pkg::t_uop w_uop;
    logic signed [DW-1:0] w_opa, w_opb, w_wdata;
    logic signed [DW:0]   w_sum;
    logic signed [DW-1:0] w_alu;
    logic                 w_alu_sat;
    logic                 w_wr, w_wsat;
    logic                 w_mul_start, w_mul_done, w_mul_sat;
    logic signed [DW-1:0] w_mul_res;
    logic                 w_in_acc, w_out_free;
    logic [FW-1:0]        w_cfg_ext;
    logic signed [DW-1:0] w_cfg_val;

    function automatic logic signed [DW-1:0] clamp_in(input logic signed [FW-1:0] x);
        logic [FW-DW:0] top;
        top = x[FW-1:DW-1];
        if (top == '0 || top == '1) return x[DW-1:0];
        return x[FW-1] ? MINV : MAXV;
    endfunction

    assign w_uop      = nmk_pkg::uc_rom(r_upc);
    assign w_in_acc   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // Operand selection; the axis bit picks the heave or pitch set.
    always_comb begin
        w_opa = '0;
        w_opb = '0;
        case (w_uop.src_a)
            nmk_pkg::SRC_H2:   w_opa = r_h2;
            nmk_pkg::SRC_Q:    w_opa = r_q4;
            nmk_pkg::SRC_MASS: w_opa = r_axis ? r_pmass : r_hmass;
            nmk_pkg::SRC_DAMP: w_opa = r_axis ? r_pdamp : r_hdamp;
            nmk_pkg::SRC_RINV: w_opa = r_axis ? r_prinv : r_hrinv;
            nmk_pkg::SRC_Y:    w_opa = r_axis ? r_py : r_hy;
            nmk_pkg::SRC_V:    w_opa = r_axis ? r_pv : r_hv;
            nmk_pkg::SRC_A:    w_opa = r_axis ? r_pa : r_ha;
            nmk_pkg::SRC_F:    w_opa = r_axis ? r_pf : r_hf;
            nmk_pkg::SRC_T0:   w_opa = r_t0;
            nmk_pkg::SRC_T1:   w_opa = r_t1;
            nmk_pkg::SRC_T2:   w_opa = r_t2;
            nmk_pkg::SRC_T3:   w_opa = r_t3;
            nmk_pkg::SRC_T4:   w_opa = r_t4;
            default:           w_opa = '0;
        endcase
        case (w_uop.src_b)
            nmk_pkg::SRC_H2:   w_opb = r_h2;
            nmk_pkg::SRC_Q:    w_opb = r_q4;
            nmk_pkg::SRC_MASS: w_opb = r_axis ? r_pmass : r_hmass;
            nmk_pkg::SRC_DAMP: w_opb = r_axis ? r_pdamp : r_hdamp;
            nmk_pkg::SRC_RINV: w_opb = r_axis ? r_prinv : r_hrinv;
            nmk_pkg::SRC_Y:    w_opb = r_axis ? r_py : r_hy;
            nmk_pkg::SRC_V:    w_opb = r_axis ? r_pv : r_hv;
            nmk_pkg::SRC_A:    w_opb = r_axis ? r_pa : r_ha;
            nmk_pkg::SRC_F:    w_opb = r_axis ? r_pf : r_hf;
            nmk_pkg::SRC_T0:   w_opb = r_t0;
            nmk_pkg::SRC_T1:   w_opb = r_t1;
            nmk_pkg::SRC_T2:   w_opb = r_t2;
            nmk_pkg::SRC_T3:   w_opb = r_t3;
            nmk_pkg::SRC_T4:   w_opb = r_t4;
            default:           w_opb = '0;
        endcase
    end

    // Saturating add and subtract with one guard bit.
    always_comb begin
        if (w_uop.op == nmk_pkg::OP_SUB) w_sum = {w_opa[DW-1], w_opa} - {w_opb[DW-1], w_opb};
        else w_sum = {w_opa[DW-1], w_opa} + {w_opb[DW-1], w_opb};
        w_alu_sat = (w_sum[DW] != w_sum[DW-1]);
        if (w_alu_sat) w_alu = w_sum[DW] ? MINV : MAXV;
        else w_alu = w_sum[DW-1:0];
    end

    nmk_mul #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mul_start),
        .i_a      (w_opa),
        .i_b      (w_opb),
        .o_done   (w_mul_done),
        .o_result (w_mul_res),
        .o_sat    (w_mul_sat)
    );

    // Sequencer: step counter, jumps and the handoff to the multiplier.
    always_comb begin
        n_state     = r_state;
        n_upc       = r_upc;
        n_axis      = r_axis;
        w_mul_start = 1'b0;
        w_wr        = 1'b0;
        w_wdata     = w_alu;
        w_wsat      = w_alu_sat;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_EXEC;
                    n_upc   = '0;
                    n_axis  = 1'b0;
                end
            end
            S_EXEC: begin
                case (w_uop.op)
                    nmk_pkg::OP_ADD, nmk_pkg::OP_SUB: begin
                        w_wr  = 1'b1;
                        n_upc = r_upc + 1'b1;
                    end
                    nmk_pkg::OP_MUL: begin
                        w_mul_start = 1'b1;
                        n_state     = S_MULW;
                    end
                    nmk_pkg::OP_DONE: begin
                        if (w_out_free) n_state = S_IDLE;
                    end
                    default: begin
                        n_upc = r_upc + 1'b1;
                        case (w_uop.jc)
                            nmk_pkg::J_DISABLED: if (!r_en) n_upc = w_uop.target;
                            nmk_pkg::J_AXIS_LOOP: begin
                                n_axis = ~r_axis;
                                if (!r_axis) n_upc = w_uop.target;
                            end
                            default: ;
                        endcase
                    end
                endcase
            end
            S_MULW: begin
                w_wdata = w_mul_res;
                w_wsat  = w_mul_sat;
                if (w_mul_done) begin
                    w_wr    = 1'b1;
                    n_upc   = r_upc + 1'b1;
                    n_state = S_EXEC;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_upc   <= '0;
            r_axis  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_upc   <= n_upc;
            r_axis  <= n_axis;
        end
    end

    // Configuration writes; a value beyond the signed range is clamped.
    assign w_cfg_ext = {1'b0, i_cfg_data};
    assign w_cfg_val = (|w_cfg_ext[FW-1:DW-1]) ? MAXV : w_cfg_ext[DW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h2    <= '0;
            r_q4    <= '0;
            r_hmass <= '0;
            r_hdamp <= '0;
            r_hrinv <= '0;
            r_pmass <= '0;
            r_pdamp <= '0;
            r_prinv <= '0;
        end else if (i_cfg_we) begin
            case (nmk_pkg::t_reg_idx'(i_cfg_index))
                nmk_pkg::REG_TWO_OVER_STEP:       r_h2    <= w_cfg_val;
                nmk_pkg::REG_FOUR_OVER_STEP_SQ:   r_q4    <= w_cfg_val;
                nmk_pkg::REG_HEAVE_MASS:          r_hmass <= w_cfg_val;
                nmk_pkg::REG_HEAVE_DAMPING:       r_hdamp <= w_cfg_val;
                nmk_pkg::REG_HEAVE_INV_STIFFNESS: r_hrinv <= w_cfg_val;
                nmk_pkg::REG_PITCH_INERTIA:       r_pmass <= w_cfg_val;
                nmk_pkg::REG_PITCH_DAMPING:       r_pdamp <= w_cfg_val;
                nmk_pkg::REG_PITCH_INV_STIFFNESS: r_prinv <= w_cfg_val;
                default: ;
            endcase
        end
    end

    // The new state of an axis is committed only after its last use of the
    // old displacement, velocity and acceleration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hy <= '0;
            r_hv <= '0;
            r_ha <= '0;
            r_py <= '0;
            r_pv <= '0;
            r_pa <= '0;
        end else if (r_state == S_EXEC && w_uop.op == nmk_pkg::OP_NOP && w_uop.commit) begin
            if (r_axis) begin
                r_py <= r_t3;
                r_pv <= r_t4;
                r_pa <= r_t0;
            end else begin
                r_hy <= r_t3;
                r_hv <= r_t4;
                r_ha <= r_t0;
            end
        end
    end

    // Captured loads and the temporaries need no reset.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_hf  <= clamp_in(i_in_data.heave_force);
            r_pf  <= clamp_in(i_in_data.pitch_moment);
            r_en  <= i_in_data.integrate_enable;
            r_sat <= 1'b0;
        end else if (w_wr && w_wsat) begin
            r_sat <= 1'b1;
        end
        if (w_wr) begin
            case (w_uop.dst)
                nmk_pkg::DST_T0: r_t0 <= w_wdata;
                nmk_pkg::DST_T1: r_t1 <= w_wdata;
                nmk_pkg::DST_T2: r_t2 <= w_wdata;
                nmk_pkg::DST_T3: r_t3 <= w_wdata;
                nmk_pkg::DST_T4: r_t4 <= w_wdata;
                default: ;
            endcase
        end
    end

    // Output register; the next transaction can start while it waits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_EXEC && w_uop.op == nmk_pkg::OP_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC && w_uop.op == nmk_pkg::OP_DONE && w_out_free) begin
            r_out.heave_disp  <= FW'(r_hy);
            r_out.heave_vel   <= FW'(r_hv);
            r_out.heave_acc   <= FW'(r_ha);
            r_out.pitch_angle <= FW'(r_py);
            r_out.pitch_rate  <= FW'(r_pv);
            r_out.pitch_accel <= FW'(r_pa);
            r_out.saturated   <= r_sat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### rtl/nmk_mul.sv
// Sequential signed fixed-point multiplier: four 32x32 partial products,
// then round to nearest on the magnitude and clamp to the signed range.
module nmk_mul #(
    parameter int DATA_WIDTH = 64,
    parameter int FRAC_BITS  = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [DATA_WIDTH-1:0] i_a,
    input  logic signed [DATA_WIDTH-1:0] i_b,
    output logic                         o_done,
    output logic signed [DATA_WIDTH-1:0] o_result,
    output logic                         o_sat
);

    localparam int HW = nmk_pkg::MUL_HALF_W;
    localparam int MW = nmk_pkg::MUL_MAG_W;
    localparam int PW = nmk_pkg::MUL_PROD_W;
    localparam logic signed [DATA_WIDTH-1:0] MAXV = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] MINV = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    typedef enum logic [3:0] {
        M_IDLE  = 4'b0001,
        M_ACC   = 4'b0010,
        M_ROUND = 4'b0100,
        M_FINAL = 4'b1000
    } t_mstate;

    t_mstate r_state, n_state;
    logic [1:0]          r_cnt;
    logic [MW-1:0]       r_x, r_y;
    logic                r_neg;
    logic [PW-1:0]       r_acc;
    logic [DATA_WIDTH:0] r_q;
    logic                r_hi;

    logic [DATA_WIDTH-1:0] w_amag, w_bmag;
    logic [HW-1:0]         w_xp, w_yp;
    logic [MW-1:0]         w_pp;
    logic [6:0]            w_shamt;
    logic [PW-1:0]         w_rsum, w_shift;
    logic [DATA_WIDTH:0]   w_lim;
    logic [DATA_WIDTH-1:0] w_neg_q;

    assign w_amag  = i_a[DATA_WIDTH-1] ? (~i_a + 1'b1) : i_a;
    assign w_bmag  = i_b[DATA_WIDTH-1] ? (~i_b + 1'b1) : i_b;
    assign w_xp    = r_cnt[1] ? r_x[MW-1:HW] : r_x[HW-1:0];
    assign w_yp    = r_cnt[0] ? r_y[MW-1:HW] : r_y[HW-1:0];
    assign w_pp    = w_xp * w_yp;
    assign w_shamt = ({6'd0, r_cnt[1]} + {6'd0, r_cnt[0]}) << 5;
    assign w_rsum  = r_acc + (PW'(1) << (FRAC_BITS - 1));
    assign w_shift = w_rsum >> FRAC_BITS;

    // The negative limit is one larger than the positive one.
    assign w_lim   = ((DATA_WIDTH+1)'(1) << (DATA_WIDTH - 1)) - {{DATA_WIDTH{1'b0}}, ~r_neg};
    assign w_neg_q = ~r_q[DATA_WIDTH-1:0] + 1'b1;

    always_comb begin
        n_state = r_state;
        case (r_state)
            M_IDLE:  if (i_start) n_state = M_ACC;
            M_ACC:   if (r_cnt == 2'd3) n_state = M_ROUND;
            M_ROUND: n_state = M_FINAL;
            M_FINAL: n_state = M_IDLE;
            default: n_state = M_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_cnt   <= 2'd0;
        end else begin
            r_state <= n_state;
            if (r_state == M_ACC) r_cnt <= r_cnt + 2'd1;
            else r_cnt <= 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            M_IDLE: begin
                r_x   <= MW'(w_amag);
                r_y   <= MW'(w_bmag);
                r_neg <= i_a[DATA_WIDTH-1] ^ i_b[DATA_WIDTH-1];
                r_acc <= '0;
            end
            M_ACC: r_acc <= r_acc + (PW'(w_pp) << w_shamt);
            M_ROUND: begin
                r_q  <= w_shift[DATA_WIDTH:0];
                r_hi <= |w_shift[PW-1:DATA_WIDTH+1];
            end
            default: ;
        endcase
    end

    always_comb begin
        o_done   = (r_state == M_FINAL);
        o_sat    = r_hi || (r_q > w_lim);
        if (o_sat) o_result = r_neg ? MINV : MAXV;
        else if (r_neg) o_result = w_neg_q;
        else o_result = r_q[DATA_WIDTH-1:0];
    end

endmodule
